// ----- src/tfb_pkg.sv -----
// ----------------------------------------------------------------------------
// tfb_pkg: shared definitions for the trellis forward/backward engine
// Request, status and register codes, field widths and default sizes.
// ----------------------------------------------------------------------------
package tfb_pkg;

  // default sizes
  localparam int MaxStatesDef  = 16;
  localparam int MaxStepsDef   = 1024;
  localparam int ValueWidthDef = 24;

  // max-log "minus infinity" and log fraction bits
  localparam int LogInf  = 1 << 10;
  localparam int LogFrac = 10;

  // field widths
  localparam int ReqW   = 2;
  localparam int StW    = 4;
  localparam int StepW  = 11;
  localparam int LinkW  = 4;
  localparam int MetW   = 24;
  localparam int StatW  = 2;
  localparam int ValW   = 24;
  localparam int CfgIdxW = 2;
  localparam int CfgW   = 11;

  // stream widths
  localparam int InDataW  = 56;
  localparam int OutDataW = 24;

  // request codes
  localparam logic [ReqW-1:0] REQ_LINK   = 2'd0;
  localparam logic [ReqW-1:0] REQ_METRIC = 2'd1;
  localparam logic [ReqW-1:0] REQ_RUN    = 2'd2;
  localparam logic [ReqW-1:0] REQ_READ   = 2'd3;

  // status codes
  localparam logic [StatW-1:0] STAT_OK    = 2'd0;
  localparam logic [StatW-1:0] STAT_RANGE = 2'd1;
  localparam logic [StatW-1:0] STAT_ZERO  = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_NUM_STATES  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DECODE_MODE = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_LEN   = 2'd2;

endpackage

// ----- src/tfb_div.sv -----
// ----------------------------------------------------------------------------
// tfb_div: unsigned restoring divider
// One quotient bit per cycle; done pulses as the last quotient bit is registered.
// ----------------------------------------------------------------------------
module tfb_div #(
  parameter int NUM_W = 46,
  parameter int DEN_W = 29
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int CntW = $clog2(NUM_W + 1);

  logic             busy_q, done_q;
  logic [CntW-1:0]  cnt_q;
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [DEN_W:0]   trial;
  logic             qbit;

  always_comb begin
    trial = {rem_q, num_q[NUM_W-1]};
    qbit  = (trial >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CntW'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      // shift numerator out, quotient in
      num_q <= {num_q[NUM_W-2:0], qbit};
      rem_q <= qbit ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

// ----- src/trellis_forward_backward.sv -----
// ----------------------------------------------------------------------------
// trellis_forward_backward: BCJR forward/backward state-metric engine
// Computes alpha and beta metrics over a trellis, MAP or max-log-MAP.
// ----------------------------------------------------------------------------
// Link/metric loads register their result on acceptance; a read goes
// through a wait state and an output state that holds until the output slot
// is free. A run seeds the rows, then does a forward and a backward pass over
// L frame steps and NS states in use; MAP mode divides one bit per cycle.
// Throughput: one transaction at a time; set by the shared multiply/add unit
// and, in MAP mode, mostly by the serial divider.
// Reset: asynchronous, active low; clears control, registers and the zero flag.
// ----------------------------------------------------------------------------
module trellis_forward_backward
  import tfb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // config write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: state_index, branch_bit, step_index, prev_link, next_link, metric,
  //        which_set, zero fill
  input  logic [InDataW-1:0]  s_axis_tdata,
  // tuser: req_type
  input  logic [ReqW-1:0]     s_axis_tuser,
  // output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: value
  output logic [OutDataW-1:0] m_axis_tdata,
  // tuser: status
  output logic [StatW-1:0]    m_axis_tuser
);

  // sizes are tied to the fixed stream field widths
  localparam int MAX_STATES  = MaxStatesDef;
  localparam int MAX_STEPS   = MaxStepsDef;
  localparam int VALUE_WIDTH = ValueWidthDef;

  localparam int VW  = VALUE_WIDTH;
  localparam int IW  = $clog2(MAX_STATES);
  localparam int SW  = $clog2(MAX_STATES + 1);
  localparam int TW  = $clog2(2 * MAX_STATES);
  localparam int LW  = $clog2(MAX_STEPS + 1);
  localparam int MAW = $clog2(MAX_STEPS * 2 * MAX_STATES);
  localparam int SAW = $clog2((MAX_STEPS + 1) * MAX_STATES);
  localparam int MapFrac = VW - 2;
  localparam int NW  = VW + $clog2(MAX_STATES) + 1;
  localparam int AW  = 2 * VW + 1;
  localparam int XW  = 2 * VW + 2;
  localparam int QW  = VW + MapFrac;

  // sequencer states
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_INIT   = 4'd1;
  localparam logic [3:0] ST_LINK   = 4'd2;
  localparam logic [3:0] ST_FETCH  = 4'd3;
  localparam logic [3:0] ST_MUL    = 4'd4;
  localparam logic [3:0] ST_ACC    = 4'd5;
  localparam logic [3:0] ST_TERM   = 4'd6;
  localparam logic [3:0] ST_NREAD  = 4'd7;
  localparam logic [3:0] ST_NCALC  = 4'd8;
  localparam logic [3:0] ST_DIV    = 4'd9;
  localparam logic [3:0] ST_RDWAIT = 4'd10;
  localparam logic [3:0] ST_RDOUT  = 4'd11;
  localparam logic [3:0] ST_DONE   = 4'd12;

  // saturate a wide signed value to VW bits
  function automatic logic signed [VW-1:0] sat_w(input logic signed [XW-1:0] x);
    logic signed [XW-1:0] hi, lo;
    hi = XW'((64'sd1 <<< (VW - 1)) - 64'sd1);
    lo = -hi - XW'(1);
    if (x > hi) return VW'(hi);
    if (x < lo) return VW'(lo);
    return VW'(x);
  endfunction

  function automatic logic [SAW-1:0] saddr(input logic [LW-1:0] row,
                                           input logic [IW-1:0] s);
    return SAW'(int'(row) * MAX_STATES + int'(s));
  endfunction

  function automatic logic [MAW-1:0] maddr(input logic [LW-1:0] step,
                                           input logic br,
                                           input logic [IW-1:0] s);
    return MAW'((int'(step) * 2 + int'(br)) * MAX_STATES + int'(s));
  endfunction

  localparam logic signed [VW-1:0] NegInf = sat_w(-XW'(LogInf * (1 << LogFrac)));
  localparam logic signed [VW-1:0] OneMap = sat_w(XW'(64'sd1 <<< MapFrac));

  // --------------------------------------------------------------------------
  // Input field unpack
  // --------------------------------------------------------------------------
  logic [ReqW-1:0]      in_req;
  logic [StW-1:0]       in_st;
  logic                 in_br;
  logic [StepW-1:0]     in_step;
  logic [LinkW-1:0]     in_prev, in_next;
  logic signed [MetW-1:0] in_met;
  logic                 in_set;

  assign in_req  = s_axis_tuser;
  assign in_st   = s_axis_tdata[3:0];
  assign in_br   = s_axis_tdata[4];
  assign in_step = s_axis_tdata[15:5];
  assign in_prev = s_axis_tdata[19:16];
  assign in_next = s_axis_tdata[23:20];
  assign in_met  = s_axis_tdata[47:24];
  assign in_set  = s_axis_tdata[48];

  // --------------------------------------------------------------------------
  // Configuration registers and their clamped values
  // --------------------------------------------------------------------------
  logic [4:0]       cfg_ns_q;
  logic             cfg_mode_q;
  logic [CfgW-1:0]  cfg_len_q;
  logic [SW-1:0]    ns_w;
  logic [LW-1:0]    len_w;
  logic             maxlog;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_ns_q   <= 5'd8;
      cfg_mode_q <= 1'b0;
      cfg_len_q  <= CfgW'(1024);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NUM_STATES:  cfg_ns_q   <= cfg_wdata_i[4:0];
        CFG_DECODE_MODE: cfg_mode_q <= cfg_wdata_i[0];
        CFG_FRAME_LEN:   cfg_len_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_ns_q < 5'd2)                   ns_w = SW'(2);
    else if (int'(cfg_ns_q) > MAX_STATES)  ns_w = SW'(MAX_STATES);
    else                                   ns_w = SW'(cfg_ns_q);
    if (cfg_len_q == '0)                   len_w = LW'(1);
    else if (int'(cfg_len_q) > MAX_STEPS)  len_w = LW'(MAX_STEPS);
    else                                   len_w = LW'(cfg_len_q);
  end
  assign maxlog = cfg_mode_q;

  // --------------------------------------------------------------------------
  // Sequencer registers
  // --------------------------------------------------------------------------
  logic [3:0]             state_q;
  logic                   dir_q;      // 0 forward pass, 1 backward pass
  logic [LW-1:0]          step_q;     // trellis step being produced
  logic [SW-1:0]          j_q;        // state counter
  logic                   b_q;        // branch counter
  logic [LinkW-1:0]       link_q;
  logic signed [AW-1:0]   acc_q;
  logic                   any_q;
  logic signed [2*VW-1:0] prod_q;
  logic signed [NW-1:0]   norm_q;
  logic signed [VW-1:0]   tval_q;
  logic                   neg_q;
  logic                   zflag_q;
  logic [IW-1:0]          rd_st_q;
  logic [LW-1:0]          rd_step_q;
  logic                   rd_set_q, rd_bad_q;

  logic                   out_valid_q;
  logic [StatW-1:0]       out_stat_q;
  logic [OutDataW-1:0]    out_val_q;

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  logic in_fire, out_fire, slot_free;
  assign slot_free     = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && slot_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = out_valid_q && m_axis_tready;

  // --------------------------------------------------------------------------
  // Stores
  // --------------------------------------------------------------------------
  logic [LinkW-1:0]      pred_mem [2*MAX_STATES];
  logic [LinkW-1:0]      succ_mem [2*MAX_STATES];
  logic signed [VW-1:0]  met_mem  [MAX_STEPS*2*MAX_STATES];
  logic signed [VW-1:0]  fwd_mem  [(MAX_STEPS+1)*MAX_STATES];
  logic signed [VW-1:0]  bwd_mem  [(MAX_STEPS+1)*MAX_STATES];
  logic signed [VW-1:0]  tbuf     [MAX_STATES];

  logic signed [VW-1:0]  met_rd_q, fwd_rd_q, bwd_rd_q;
  logic [LinkW-1:0]      link_rd;

  logic                  link_ok, load_st_ok, met_ok, rd_ok;
  logic [TW-1:0]         tab_wr_idx, tab_rd_idx;
  logic [LW-1:0]         src_row, dst_row, mstep;
  logic [IW-1:0]         j_idx, link_idx;
  logic [SAW-1:0]        f_raddr, b_raddr, f_waddr, b_waddr;
  logic                  f_we, b_we;
  logic signed [VW-1:0]  f_wdata, b_wdata;
  logic [MAW-1:0]        m_raddr;

  assign load_st_ok = int'(in_st) < MAX_STATES;
  assign met_ok     = load_st_ok && (int'(in_step) < MAX_STEPS);
  assign rd_ok      = (int'(in_st) < int'(ns_w)) && (int'(in_step) <= int'(len_w));
  assign tab_wr_idx = TW'(int'(in_st) + int'(in_br) * MAX_STATES);
  assign j_idx      = j_q[IW-1:0];
  assign link_idx   = IW'(link_q);
  assign tab_rd_idx = TW'(int'(j_idx) + int'(b_q) * MAX_STATES);
  assign link_ok    = int'(link_q) < int'(ns_w);
  assign mstep      = step_q - 1'b1;
  assign src_row    = dir_q ? step_q : mstep;
  assign dst_row    = dir_q ? mstep : step_q;
  assign m_raddr    = maddr(mstep, b_q, dir_q ? j_idx : link_idx);

  always_comb begin
    if (state_q == ST_RDWAIT) begin
      f_raddr = saddr(rd_step_q, rd_st_q);
      b_raddr = saddr(rd_step_q, rd_st_q);
    end else begin
      f_raddr = saddr(src_row, link_idx);
      b_raddr = saddr(src_row, link_idx);
    end
  end

  // link tables: load on accept, read one link per cycle
  always_ff @(posedge clk_i) begin
    if (in_fire && in_req == REQ_LINK && load_st_ok) begin
      pred_mem[tab_wr_idx] <= in_prev;
      succ_mem[tab_wr_idx] <= in_next;
    end
  end
  assign link_rd = dir_q ? succ_mem[tab_rd_idx] : pred_mem[tab_rd_idx];

  always_ff @(posedge clk_i) begin
    if (in_fire && in_req == REQ_METRIC && met_ok) begin
      met_mem[maddr(LW'(in_step), in_br, IW'(in_st))] <=
        sat_w(XW'(in_met));
    end
    met_rd_q <= met_mem[m_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (f_we) fwd_mem[f_waddr] <= f_wdata;
    fwd_rd_q <= fwd_mem[f_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) bwd_mem[b_waddr] <= b_wdata;
    bwd_rd_q <= bwd_mem[b_raddr];
  end

  // --------------------------------------------------------------------------
  // Shared datapath
  // --------------------------------------------------------------------------
  logic signed [VW-1:0]  src_val, term_w, t_w, lm_w, q_sat, dst_w, none_w;
  logic signed [NW-1:0]  norm_nx, norm_init;
  logic signed [VW:0]    t_ext;
  logic signed [NW:0]    n_ext;
  logic [VW:0]           t_abs;
  logic [NW:0]           n_abs;
  logic [QW-1:0]         div_num, div_quot;
  logic [NW-1:0]         div_den;
  logic signed [XW-1:0]  q_signed;
  logic                  div_start, div_done, wr_dst, last_j;

  assign src_val   = dir_q ? bwd_rd_q : fwd_rd_q;
  assign term_w    = sat_w(XW'(src_val) + XW'(met_rd_q));
  assign t_w       = maxlog ? (any_q ? VW'(acc_q) : NegInf)
                            : sat_w(XW'(acc_q >>> MapFrac));
  assign norm_nx   = maxlog ? ((NW'(t_w) > norm_q) ? NW'(t_w) : norm_q)
                            : norm_q + NW'(t_w);
  assign norm_init = maxlog ? NW'(NegInf) : '0;
  assign none_w    = maxlog ? NegInf : '0;
  assign lm_w      = sat_w(XW'(tval_q) - XW'(norm_q));
  assign last_j    = (j_q + 1'b1) >= ns_w;

  // magnitudes for the divider
  assign t_ext   = (VW+1)'(tval_q);
  assign t_abs   = (t_ext < 0) ? (VW+1)'(-t_ext) : (VW+1)'(t_ext);
  assign n_ext   = (NW+1)'(norm_q);
  assign n_abs   = (n_ext < 0) ? (NW+1)'(-n_ext) : (NW+1)'(n_ext);
  assign div_num = {t_abs[VW-1:0], {MapFrac{1'b0}}};
  assign div_den = n_abs[NW-1:0];
  assign div_start = (state_q == ST_NCALC) && !maxlog && (norm_q != '0);
  assign q_signed  = neg_q ? -signed'(XW'(div_quot)) : signed'(XW'(div_quot));
  assign q_sat     = sat_w(q_signed);

  tfb_div #(
    .NUM_W (QW),
    .DEN_W (NW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // destination write for the normalized metric
  always_comb begin
    wr_dst = 1'b0;
    dst_w  = '0;
    if (state_q == ST_NCALC && maxlog) begin
      wr_dst = 1'b1;
      dst_w  = lm_w;
    end else if (state_q == ST_NCALC && norm_q == '0) begin
      wr_dst = 1'b1;
      dst_w  = '0;
    end else if (state_q == ST_DIV && div_done) begin
      wr_dst = 1'b1;
      dst_w  = q_sat;
    end
  end

  always_comb begin
    if (state_q == ST_INIT) begin
      f_we    = 1'b1;
      b_we    = 1'b1;
      f_waddr = saddr('0, j_idx);
      b_waddr = saddr(len_w, j_idx);
      f_wdata = (j_q == '0) ? (maxlog ? '0 : OneMap) : none_w;
      b_wdata = f_wdata;
    end else begin
      f_we    = wr_dst && !dir_q;
      b_we    = wr_dst && dir_q;
      f_waddr = saddr(dst_row, j_idx);
      b_waddr = saddr(dst_row, j_idx);
      f_wdata = dst_w;
      b_wdata = dst_w;
    end
  end

  // t buffer: written per state in phase one, read back in phase two
  always_ff @(posedge clk_i) begin
    if (state_q == ST_TERM) tbuf[j_idx] <= t_w;
    tval_q <= tbuf[j_idx];
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dir_q       <= 1'b0;
      step_q      <= '0;
      j_q         <= '0;
      b_q         <= 1'b0;
      any_q       <= 1'b0;
      zflag_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_stat_q  <= STAT_OK;
      out_val_q   <= '0;
    end else begin
      if (out_fire) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            case (in_req)
              REQ_LINK: begin
                out_valid_q <= 1'b1;
                out_stat_q  <= load_st_ok ? STAT_OK : STAT_RANGE;
                out_val_q   <= '0;
              end
              REQ_METRIC: begin
                out_valid_q <= 1'b1;
                out_stat_q  <= met_ok ? STAT_OK : STAT_RANGE;
                out_val_q   <= '0;
              end
              REQ_RUN: begin
                zflag_q <= 1'b0;
                j_q     <= '0;
                state_q <= ST_INIT;
              end
              default: begin
                state_q <= ST_RDWAIT;
              end
            endcase
          end
        end
        ST_INIT: begin
          // seed alpha row 0 and beta row L
          if (last_j) begin
            j_q     <= '0;
            b_q     <= 1'b0;
            any_q   <= 1'b0;
            dir_q   <= 1'b0;
            step_q  <= LW'(1);
            state_q <= ST_LINK;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        ST_LINK:  state_q <= ST_FETCH;
        ST_FETCH: begin
          // drop a branch that points at an unused state
          if (link_ok)        state_q <= ST_MUL;
          else if (!b_q)      begin b_q <= 1'b1; state_q <= ST_LINK; end
          else                state_q <= ST_TERM;
        end
        ST_MUL: begin
          if (maxlog) begin
            any_q <= 1'b1;
            if (!b_q) begin b_q <= 1'b1; state_q <= ST_LINK; end
            else      state_q <= ST_TERM;
          end else begin
            state_q <= ST_ACC;
          end
        end
        ST_ACC: begin
          any_q <= 1'b1;
          if (!b_q) begin b_q <= 1'b1; state_q <= ST_LINK; end
          else      state_q <= ST_TERM;
        end
        ST_TERM: begin
          b_q   <= 1'b0;
          any_q <= 1'b0;
          if (last_j) begin
            if (!maxlog && norm_nx == '0) zflag_q <= 1'b1;
            j_q     <= '0;
            state_q <= ST_NREAD;
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= ST_LINK;
          end
        end
        ST_NREAD: state_q <= ST_NCALC;
        ST_NCALC, ST_DIV: begin
          if (div_start) begin
            state_q <= ST_DIV;
          end else if (wr_dst) begin
            if (!last_j) begin
              j_q     <= j_q + 1'b1;
              state_q <= ST_NREAD;
            end else begin
              // step finished: advance the pass or turn around
              j_q <= '0;
              if (!dir_q) begin
                if (step_q == len_w) begin
                  dir_q  <= 1'b1;
                  step_q <= len_w;
                end else begin
                  step_q <= step_q + 1'b1;
                end
                state_q <= ST_LINK;
              end else if (step_q == LW'(1)) begin
                state_q <= ST_DONE;
              end else begin
                step_q  <= mstep;
                state_q <= ST_LINK;
              end
            end
          end
        end
        ST_RDWAIT: state_q <= ST_RDOUT;
        ST_RDOUT: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            if (rd_bad_q) begin
              out_stat_q <= STAT_RANGE;
              out_val_q  <= '0;
            end else begin
              out_stat_q <= zflag_q ? STAT_ZERO : STAT_OK;
              out_val_q  <= OutDataW'(rd_set_q ? bwd_rd_q : fwd_rd_q);
            end
            state_q <= ST_IDLE;
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_stat_q  <= zflag_q ? STAT_ZERO : STAT_OK;
            out_val_q   <= '0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (state_q == ST_LINK) link_q <= link_rd;
    if (state_q == ST_MUL) begin
      if (maxlog) begin
        if (!any_q || AW'(term_w) > acc_q) acc_q <= AW'(term_w);
      end else begin
        prod_q <= src_val * met_rd_q;
      end
    end
    if (state_q == ST_ACC) acc_q <= acc_q + AW'(prod_q);
    if (state_q == ST_TERM) begin
      acc_q  <= '0;
      norm_q <= norm_nx;
    end
    if (state_q == ST_INIT) begin
      acc_q  <= '0;
      norm_q <= norm_init;
    end
    if (wr_dst && last_j) norm_q <= norm_init;
    if (div_start) neg_q <= tval_q[VW-1] ^ norm_q[NW-1];
    if (in_fire && in_req == REQ_READ) begin
      rd_st_q   <= IW'(in_st);
      rd_step_q <= LW'(in_step);
      rd_set_q  <= in_set;
      rd_bad_q  <= !rd_ok;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_val_q;
  assign m_axis_tuser  = out_stat_q;

`ifndef ASSERT_OFF
  a_div_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide state");

  a_load_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_req == REQ_LINK || in_req == REQ_METRIC) |=> out_valid_q)
    else $error("load transaction gave no result");

  a_state_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LINK |-> j_q < ns_w)
    else $error("state counter beyond states in use");

  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !s_axis_tready)
    else $error("input accepted while a run or read is in progress");
`endif

endmodule
